[rtl/core/rdc_pkg.sv]
// shared types and constants of the radix digit converter
package rdc_pkg;

  localparam int unsigned VALUE_IN_W = 31;
  localparam int unsigned RADIX_W    = 8;
  localparam int unsigned DIGIT_W    = 4;
  localparam int unsigned DIVISOR_W  = 5;
  localparam int unsigned STEP_BITS  = 8;
  localparam int unsigned S_TDATA_W  = 40;
  localparam int unsigned M_TDATA_W  = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 8'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX = 8'd16;

  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_BAD,
    KIND_CONV
  } kind_e;

  typedef struct packed {
    logic dividing;
    logic emitting;
  } rdc_status_t;

endpackage

[rtl/core/rdc_front.sv]
// input side: takes beats, classifies them and holds them in a two-entry queue
module rdc_front import rdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [VALUE_IN_W-1:0]  in_value_i,
  input  logic [RADIX_W-1:0]     in_radix_i,
  output logic                   q_valid_o,
  input  logic                   q_ready_i,
  output kind_e                  q_kind_o,
  output logic [VALUE_WIDTH-1:0] q_value_o,
  output logic [DIVISOR_W-1:0]   q_radix_o
);

  localparam int unsigned EXT_W  = VALUE_WIDTH + VALUE_IN_W;
  localparam logic [1:0]  QDEPTH = 2'd2;

  logic [EXT_W-1:0]       value_ext;
  logic [VALUE_WIDTH-1:0] value_in;
  kind_e                  kind_in;
  logic                   push, pop;

  kind_e                  kind_q  [2];
  logic [VALUE_WIDTH-1:0] value_q [2];
  logic [DIVISOR_W-1:0]   radix_q [2];
  logic                   wr_ptr_q, wr_ptr_d;
  logic                   rd_ptr_q, rd_ptr_d;
  logic [1:0]             count_q, count_d;

  // only the low VALUE_WIDTH bits of the value take part
  assign value_ext = EXT_W'(in_value_i);
  assign value_in  = value_ext[VALUE_WIDTH-1:0];

  always_comb begin
    if (value_in == '0) begin
      kind_in = KIND_ZERO;
    end else if ((in_radix_i < RADIX_MIN) || (in_radix_i > RADIX_MAX)) begin
      kind_in = KIND_BAD;
    end else begin
      kind_in = KIND_CONV;
    end
  end

  assign in_ready_o = (count_q != QDEPTH);
  assign q_valid_o  = (count_q != 2'd0);
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  assign q_kind_o  = kind_q[rd_ptr_q];
  assign q_value_o = value_q[rd_ptr_q];
  assign q_radix_o = radix_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      kind_q[wr_ptr_q]  <= kind_in;
      value_q[wr_ptr_q] <= value_in;
      radix_q[wr_ptr_q] <= in_radix_i[DIVISOR_W-1:0];
    end
  end

endmodule

[rtl/core/rdc_back.sv]
// work side: iterative division by the radix, digit store and digit read-out
module rdc_back import rdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  output logic                   q_ready_o,
  input  kind_e                  q_kind_i,
  input  logic [VALUE_WIDTH-1:0] q_value_i,
  input  logic [DIVISOR_W-1:0]   q_radix_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [DIGIT_W-1:0]     out_digit_o,
  output logic                   out_last_o,
  output logic                   out_error_o,
  output rdc_status_t            status_o
);

  localparam int unsigned PAD_W  = ((VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS) * STEP_BITS;
  localparam int unsigned NCH    = PAD_W / STEP_BITS;
  localparam int unsigned CH_W   = (NCH > 1) ? $clog2(NCH) : 1;
  localparam int unsigned ADDR_W = $clog2(VALUE_WIDTH);
  localparam int unsigned CNT_W  = $clog2(VALUE_WIDTH + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0]           state_q, state_d;
  logic [PAD_W-1:0]     div_q, div_d, div_nx;
  logic [DIVISOR_W-1:0] radix_q, radix_d;
  logic [DIGIT_W-1:0]   rem_q, rem_d, rem_nx;
  logic [CH_W-1:0]      chunk_q, chunk_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic [ADDR_W-1:0]    rd_idx_q, rd_idx_d;
  logic                 out_valid_q, out_valid_d;
  logic [DIGIT_W-1:0]   out_digit_q, out_digit_d;
  logic                 out_last_q, out_last_d;
  logic                 out_error_q, out_error_d;
  logic [STEP_BITS-1:0] qbits;
  logic [PAD_W+STEP_BITS-1:0] quot_ext;
  logic                 out_free;
  logic                 wr_en, rd_en;

  logic [DIGIT_W-1:0]   store_q [VALUE_WIDTH];
  logic [DIGIT_W-1:0]   rd_data_q;

  // one chunk of the long division: a few restoring steps on a narrow remainder
  always_comb begin
    logic [DIGIT_W-1:0]   r;
    logic [DIVISOR_W-1:0] t;
    logic [STEP_BITS-1:0] top;
    top = div_q[PAD_W-1 -: STEP_BITS];
    r   = rem_q;
    for (int i = 0; i < STEP_BITS; i++) begin
      t = {r, top[STEP_BITS-1-i]};
      if (t >= radix_q) begin
        qbits[STEP_BITS-1-i] = 1'b1;
        r = DIGIT_W'(t - radix_q);
      end else begin
        qbits[STEP_BITS-1-i] = 1'b0;
        r = t[DIGIT_W-1:0];
      end
    end
    rem_nx = r;
  end

  // dividend shifts out at the top while quotient bits come in at the bottom
  assign quot_ext = {div_q, qbits};
  assign div_nx   = quot_ext[PAD_W-1:0];

  assign out_free  = !out_valid_q || out_ready_i;
  assign q_ready_o = (state_q == ST_IDLE) && ((q_kind_i == KIND_CONV) || out_free);

  always_comb begin
    state_d     = state_q;
    div_d       = div_q;
    radix_d     = radix_q;
    rem_d       = rem_q;
    chunk_d     = chunk_q;
    cnt_d       = cnt_q;
    rd_idx_d    = rd_idx_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;
    out_error_d = out_error_q;
    wr_en       = 1'b0;
    rd_en       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && q_ready_o) begin
          if (q_kind_i == KIND_CONV) begin
            div_d   = PAD_W'(q_value_i);
            radix_d = q_radix_i;
            rem_d   = '0;
            chunk_d = '0;
            cnt_d   = '0;
            state_d = ST_DIV;
          end else begin
            out_valid_d = 1'b1;
            out_digit_d = '0;
            out_last_d  = 1'b1;
            out_error_d = (q_kind_i == KIND_BAD);
          end
        end
      end
      ST_DIV: begin
        div_d   = div_nx;
        rem_d   = rem_nx;
        chunk_d = chunk_q + CH_W'(1);
        if (chunk_q == CH_W'(NCH - 1)) begin
          chunk_d = '0;
          rem_d   = '0;
          wr_en   = 1'b1;
          cnt_d   = cnt_q + CNT_W'(1);
          if ((div_nx == '0) || (cnt_q == CNT_W'(VALUE_WIDTH - 1))) begin
            rd_idx_d = cnt_q[ADDR_W-1:0];
            state_d  = ST_RD;
          end
        end
      end
      ST_RD: begin
        rd_en   = 1'b1;
        state_d = ST_LOAD;
      end
      ST_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_digit_d = rd_data_q;
          out_last_d  = (rd_idx_q == '0);
          out_error_d = 1'b0;
          if (rd_idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            rd_idx_d = rd_idx_q - ADDR_W'(1);
            state_d  = ST_RD;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      chunk_q     <= chunk_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    div_q       <= div_d;
    radix_q     <= radix_d;
    rem_q       <= rem_d;
    rd_idx_q    <= rd_idx_d;
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
    out_error_q <= out_error_d;
  end

  // digit store, least significant digit at address zero
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_q[cnt_q[ADDR_W-1:0]] <= rem_nx;
    end
    if (rd_en) begin
      rd_data_q <= store_q[rd_idx_q];
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_digit_o       = out_digit_q;
  assign out_last_o        = out_last_q;
  assign out_error_o       = out_error_q;
  assign status_o.dividing = (state_q == ST_DIV);
  assign status_o.emitting = (state_q == ST_RD) || (state_q == ST_LOAD);

endmodule

[rtl/core/radix_digit_converter_unit.sv]
// top level of the radix digit converter: stream ports, front queue and back end
// Each input beat carries a value and a radix; the unit emits the digits of the value in that
// radix, most significant first, one output beat per digit with tlast on the final digit. A zero
// value gives the single digit 0; a nonzero value with a radix outside 2..16 gives one beat with
// tuser (error) set and digit 0. Only the low VALUE_WIDTH bits of the value are used. A
// conversion runs in the back end: the shared divider retires eight dividend bits per cycle
// against the radix, and each digit is then read back through the registered port of the
// digit store, in a read state and then a load state that waits for the output to be free.
// Zero and error items bypass the divider. A two-entry queue in front accepts new items
// while the back end is busy or its output is stalled.
module radix_digit_converter_unit import rdc_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 31
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [S_TDATA_W-1:0] s_axis_tdata,   // value [30:0], radix [38:31], zero pad
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [M_TDATA_W-1:0] m_axis_tdata,   // digit [3:0], zero pad
  output logic                 m_axis_tlast,
  output logic                 m_axis_tuser    // error
);

  logic                   q_valid, q_ready;
  kind_e                  q_kind;
  logic [VALUE_WIDTH-1:0] q_value;
  logic [DIVISOR_W-1:0]   q_radix;
  logic [DIGIT_W-1:0]     out_digit;
  rdc_status_t            status;

  rdc_front #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_value_i (s_axis_tdata[VALUE_IN_W-1:0]),
    .in_radix_i (s_axis_tdata[VALUE_IN_W +: RADIX_W]),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_kind_o   (q_kind),
    .q_value_o  (q_value),
    .q_radix_o  (q_radix)
  );

  rdc_back #(
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_kind_i    (q_kind),
    .q_value_i   (q_value),
    .q_radix_i   (q_radix),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_digit_o (out_digit),
    .out_last_o  (m_axis_tlast),
    .out_error_o (m_axis_tuser),
    .status_o    (status)
  );

  assign m_axis_tdata = M_TDATA_W'(out_digit);

  // an error beat is always a lone final beat with digit zero
  a_error_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))
    else $error("error beat without tlast or with nonzero digit");

  // the divider never loads a new output beat
  a_no_load_while_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status.dividing |=> !$rose(m_axis_tvalid))
    else $error("output beat appeared during division");

  // a pending non-final digit means the read-out of that conversion is still under way
  a_mid_digit_emitting: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> status.emitting && !m_axis_tuser)
    else $error("non-final digit outside read-out phase");

endmodule

[verif/radix_digit_converter_unit_tb.sv]
// testbench of the radix digit converter: directed and random conversions checked beat by beat
`timescale 1ns / 100ps

module radix_digit_converter_unit_tb;
  import rdc_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 250;
  localparam int unsigned HOLD_CYCLES  = 600;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               last;
    logic               error;
  } digit_beat_t;

  logic                 clk_i;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;   // value [30:0], radix [38:31], zero pad
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;         // digit [3:0], zero pad
  logic                 m_axis_tlast;
  logic                 m_axis_tuser;         // error

  // predictor state
  logic [DIGIT_W-1:0]    conv_store [VALUE_IN_W];
  logic [VALUE_IN_W-1:0] conv_quotient = '0;
  int unsigned           conv_count    = 0;

  digit_beat_t expected_digits [$];

  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned hold_left      = 0;
  int unsigned cycle_count    = 0;

  int unsigned items_sent     = 0;
  int unsigned zero_items     = 0;
  int unsigned bad_radix_items = 0;
  int unsigned beats_checked  = 0;
  int unsigned mismatch_count = 0;
  int unsigned stray_count    = 0;

  radix_digit_converter_unit DUT (
    .clk_i,
    .rst_ni,
    .s_axis_tvalid,
    .s_axis_tready,
    .s_axis_tdata,
    .m_axis_tvalid,
    .m_axis_tready,
    .m_axis_tdata,
    .m_axis_tlast,
    .m_axis_tuser
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d beats still expected", cycle_count,
               expected_digits.size());
      $display("[radix_digit_converter_unit] ERROR");
      $finish;
    end
  end

  // works out the digit beats of one conversion, most significant first
  function automatic void predict_digits(input logic [VALUE_IN_W-1:0] value,
                                         input logic [RADIX_W-1:0] radix);
    int unsigned n;
    n = 0;
    if (value == '0) begin
      conv_quotient = '0;
      conv_store[0] = '0;
      conv_count    = 1;
      zero_items++;
      expected_digits.push_back('{digit: '0, last: 1'b1, error: 1'b0});
      return;
    end
    if (radix < RADIX_MIN || radix > RADIX_MAX) begin
      conv_quotient = value;
      conv_count    = 0;
      bad_radix_items++;
      expected_digits.push_back('{digit: '0, last: 1'b1, error: 1'b1});
      return;
    end
    conv_quotient = value;
    while (conv_quotient != '0 && n < VALUE_IN_W) begin
      conv_store[n] = DIGIT_W'(conv_quotient % radix);
      conv_quotient = conv_quotient / radix;
      n++;
    end
    conv_count = n;
    for (int k = 0; k < n; k++) begin
      expected_digits.push_back('{digit: conv_store[n-1-k], last: (k == n - 1), error: 1'b0});
    end
  endfunction

  task automatic send_item(input logic [VALUE_IN_W-1:0] value,
                           input logic [RADIX_W-1:0] radix);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(S_TDATA_W - VALUE_IN_W - RADIX_W){1'b0}}, radix, value};
    do @(posedge clk_i); while (!s_axis_tready);
    predict_digits(value, radix);
    items_sent++;
  endtask

  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // zero value comes before the radix check
    send_item('0, 8'd10);
    send_item('0, 8'd0);
    send_item('0, 8'd255);
    send_item('0, 8'd1);
    // radix out of range on a nonzero value
    send_item(31'd1234, 8'd0);
    send_item(31'd1234, 8'd1);
    send_item(31'd1234, 8'd17);
    send_item('1, 8'd255);
    // widest and narrowest results
    send_item('1, 8'd2);
    send_item('1, 8'd16);
    send_item('1, 8'd3);
    send_item(31'd1, 8'd2);
    send_item(31'd1, 8'd16);
    // digit boundaries
    send_item(31'd15, 8'd16);
    send_item(31'd16, 8'd16);
    send_item(31'd255, 8'd16);
    send_item(31'h2AAA_AAAA, 8'd2);
    send_item(31'h5555_5555, 8'd2);
    send_item(31'd1000000, 8'd10);
    send_item(31'd342, 8'd7);
    send_item(31'h4000_0000, 8'd2);
    send_item(31'd2147483646, 8'd15);
  endtask

  task automatic test_random_phase(input int unsigned idle_pct, input int unsigned stall_pct,
                                   input int unsigned n_items);
    int unsigned           pick;
    int unsigned           width;
    logic [VALUE_IN_W-1:0] value;
    logic [RADIX_W-1:0]    radix;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int i = 0; i < n_items; i++) begin
      pick  = $urandom_range(99);
      width = $urandom_range(VALUE_IN_W, 1);
      value = VALUE_IN_W'($urandom) >> (VALUE_IN_W - width);
      if (value == '0) value = VALUE_IN_W'(1);
      radix = RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN));
      if (pick < 6) begin
        value = '0;
        radix = RADIX_W'($urandom_range(255));
      end else if (pick < 14) begin
        if ($urandom_range(3) == 0) radix = RADIX_W'($urandom_range(1));
        else radix = RADIX_W'($urandom_range(255, 17));
      end
      send_item(value, radix);
    end
  endtask

  // output held off long enough that the front queue fills and input stalls
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left <= HOLD_CYCLES;
    for (int i = 0; i < 8; i++) begin
      send_item(VALUE_IN_W'($urandom_range(4095, 1)),
                RADIX_W'($urandom_range(RADIX_MAX, RADIX_MIN)));
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    digit_beat_t got;
    digit_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{digit: m_axis_tdata[DIGIT_W-1:0], last: m_axis_tlast, error: m_axis_tuser};
      if (expected_digits.size() == 0) begin
        stray_count++;
        if (mismatch_count + stray_count <= MAX_REPORTS)
          $display("unexpected beat: digit %0d last %0b error %0b", got.digit, got.last,
                   got.error);
      end else begin
        want = expected_digits.pop_front();
        beats_checked++;
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count + stray_count <= MAX_REPORTS)
            $display("beat %0d: expected digit %0d last %0b error %0b, got %0d %0b %0b",
                     beats_checked, want.digit, want.last, want.error,
                     got.digit, got.last, got.error);
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_phase(0, 0, 38);
    test_random_phase(82, 0, 38);
    test_random_phase(0, 82, 38);
    test_random_phase(7, 7, 38);
    test_backpressure();

    send_idle_pct = 0;
    s_axis_tvalid <= 1'b0;
    while (expected_digits.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("%0d conversions (%0d zero, %0d bad radix), %0d digit beats checked",
             items_sent, zero_items, bad_radix_items, beats_checked);
    $display("idle and stall phases plus one long output hold-off; %0d mismatches, %0d stray",
             mismatch_count, stray_count);
    if (mismatch_count == 0 && stray_count == 0 && expected_digits.size() == 0) begin
      $display("[radix_digit_converter_unit] OK");
    end else begin
      $display("[radix_digit_converter_unit] ERROR");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/rdc_pkg.sv
rtl/core/rdc_front.sv
rtl/core/rdc_back.sv
rtl/core/radix_digit_converter_unit.sv
verif/radix_digit_converter_unit_tb.sv
